// File: sv/aip_pkg.sv
`default_nettype none
package aip_pkg;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SIGN   = 3'd1,
    PH_ZERO   = 3'd2,
    PH_DIGITS = 3'd3,
    PH_OVER   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    RAD_DEC = 2'd0,
    RAD_HEX = 2'd1,
    RAD_OCT = 2'd2,
    RAD_BIN = 2'd3
  } radix_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NAN   = 2'd1;
  localparam logic [1:0] ST_OVF   = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  localparam logic [0:0] REG_SIGNED_MODE = 1'd0;
  localparam logic [0:0] REG_WIDE_MODE   = 1'd1;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UB    = 8'h42;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LX    = 8'h78;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } digit_t;

  typedef struct packed {
    logic        fits;
    logic [63:0] acc;
  } acc_step_t;

endpackage
`default_nettype wire

// File: sv/ascii_integer_literal_parser_core.sv
// The item that ends the literal passes the input register; its result then sits in the result register on out_*.
// Throughput: one item per cycle unless stalled; the digit decode and one radix shift-add accumulate
// sit between the input register and the result register.
// Stalls only when the result register is full and out_tready is low.
// Reset (rst_n low, synchronous): signed_mode = 1, wide_mode = 0, parse state idle,
// radix ten, accumulator zero, both item registers empty.
`default_nettype none
module ascii_integer_literal_parser_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [0:0]  cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] char_code
  input  wire logic        in_tlast,   // end_of_input
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [79:0]      out_tdata,  // [63:0] value, [65:64] status,
                                       // [73:66] terminator_code, [79:74] zero
  output logic             out_tlast   // ended_by_input_end
);

  logic signed_mode_r;
  logic wide_mode_r;

  logic       in_vld_r;
  logic [7:0] in_char_r;
  logic       in_end_r;

  aip_pkg::phase_t ph_r, ph_nxt;
  aip_pkg::radix_t rad_r, rad_nxt;
  logic [63:0]     acc_r, acc_nxt;
  logic            neg_r, neg_nxt;
  logic            seen_r, seen_nxt;

  logic        out_vld_r;
  logic [63:0] out_value_r, out_value_nxt;
  logic [1:0]  out_status_r, out_status_nxt;
  logic [7:0]  out_term_r, out_term_nxt;
  logic        out_end_r, out_end_nxt;

  logic advance;
  logic process;

  aip_pkg::radix_t    dec_radix;
  aip_pkg::digit_t    digit;
  aip_pkg::acc_step_t step;

  logic       emit;
  logic [1:0] emit_status;

  assign advance   = !out_vld_r || out_tready;
  assign in_tready = !in_vld_r || advance;
  assign process   = in_vld_r && advance;

  always_comb begin
    case (ph_r)
      aip_pkg::PH_ZERO:   dec_radix = aip_pkg::RAD_OCT;
      aip_pkg::PH_DIGITS: dec_radix = rad_r;
      aip_pkg::PH_OVER:   dec_radix = rad_r;
      default:            dec_radix = aip_pkg::RAD_DEC;
    endcase
  end

  aip_digit_decode u_decode (
    .char_code (in_char_r),
    .radix     (dec_radix),
    .digit     (digit)
  );

  aip_acc_step u_acc (
    .acc       (acc_r),
    .radix     (dec_radix),
    .digit     (digit.value),
    .wide_mode (wide_mode_r),
    .step      (step)
  );

  // next parse state
  always_comb begin
    ph_nxt      = ph_r;
    rad_nxt     = rad_r;
    acc_nxt     = acc_r;
    neg_nxt     = neg_r;
    seen_nxt    = seen_r;
    emit        = 1'b0;
    emit_status = aip_pkg::ST_OK;
    case (ph_r)
      aip_pkg::PH_IDLE, aip_pkg::PH_SIGN: begin
        if (in_end_r) begin
          emit        = 1'b1;
          emit_status = aip_pkg::ST_NAN;
        end else if (ph_r == aip_pkg::PH_IDLE && signed_mode_r &&
                     (in_char_r == aip_pkg::CH_PLUS || in_char_r == aip_pkg::CH_MINUS)) begin
          neg_nxt = (in_char_r == aip_pkg::CH_MINUS);
          ph_nxt  = aip_pkg::PH_SIGN;
        end else if (in_char_r == aip_pkg::CH_0) begin
          ph_nxt = aip_pkg::PH_ZERO;
        end else if (!digit.valid) begin
          emit        = 1'b1;
          emit_status = aip_pkg::ST_NAN;
        end else if (step.fits) begin
          acc_nxt  = step.acc;
          seen_nxt = 1'b1;
          ph_nxt   = aip_pkg::PH_DIGITS;
        end else begin
          ph_nxt = aip_pkg::PH_OVER;
        end
      end
      aip_pkg::PH_ZERO: begin
        if (in_end_r) begin
          emit = 1'b1;
        end else if (in_char_r == aip_pkg::CH_LX || in_char_r == aip_pkg::CH_UX) begin
          rad_nxt = aip_pkg::RAD_HEX;
          ph_nxt  = aip_pkg::PH_DIGITS;
        end else if (in_char_r == aip_pkg::CH_LB || in_char_r == aip_pkg::CH_UB) begin
          rad_nxt = aip_pkg::RAD_BIN;
          ph_nxt  = aip_pkg::PH_DIGITS;
        end else if (digit.valid) begin
          rad_nxt = aip_pkg::RAD_OCT;
          if (step.fits) begin
            acc_nxt  = step.acc;
            seen_nxt = 1'b1;
            ph_nxt   = aip_pkg::PH_DIGITS;
          end else begin
            ph_nxt = aip_pkg::PH_OVER;
          end
        end else begin
          emit = 1'b1;
        end
      end
      aip_pkg::PH_DIGITS: begin
        if (in_end_r || !digit.valid) begin
          emit        = 1'b1;
          emit_status = seen_r ? aip_pkg::ST_OK : aip_pkg::ST_NAN;
        end else if (step.fits) begin
          acc_nxt  = step.acc;
          seen_nxt = 1'b1;
        end else begin
          ph_nxt = aip_pkg::PH_OVER;
        end
      end
      aip_pkg::PH_OVER: begin
        if (in_end_r || !digit.valid) begin
          emit        = 1'b1;
          emit_status = aip_pkg::ST_OVF;
        end
      end
      default: begin
        ph_nxt   = aip_pkg::PH_IDLE;
        rad_nxt  = aip_pkg::RAD_DEC;
        acc_nxt  = 64'd0;
        neg_nxt  = 1'b0;
        seen_nxt = 1'b0;
      end
    endcase
    if (emit) begin
      ph_nxt   = aip_pkg::PH_IDLE;
      rad_nxt  = aip_pkg::RAD_DEC;
      acc_nxt  = 64'd0;
      neg_nxt  = 1'b0;
      seen_nxt = 1'b0;
    end
  end

  // result fields
  always_comb begin
    logic        over_half;
    logic [63:0] signed_val;
    over_half  = wide_mode_r ? acc_r[63] : (acc_r[63:31] != 33'd0);
    signed_val = neg_r ? (64'd0 - acc_r) : acc_r;
    out_value_nxt  = 64'd0;
    out_status_nxt = emit_status;
    if (emit_status == aip_pkg::ST_OK) begin
      if ((signed_mode_r || neg_r) && over_half) begin
        out_status_nxt = aip_pkg::ST_RANGE;
      end else begin
        out_value_nxt = wide_mode_r ? signed_val : {32'd0, signed_val[31:0]};
      end
    end
    out_term_nxt = in_end_r ? 8'd0 : in_char_r;
    out_end_nxt  = in_end_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      signed_mode_r <= 1'b1;
      wide_mode_r   <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == aip_pkg::REG_SIGNED_MODE) begin
        signed_mode_r <= cfg_wdata[0];
      end else if (cfg_index == aip_pkg::REG_WIDE_MODE) begin
        wide_mode_r <= cfg_wdata[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      in_char_r <= in_tdata;
      in_end_r  <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= aip_pkg::PH_IDLE;
      rad_r  <= aip_pkg::RAD_DEC;
      acc_r  <= 64'd0;
      neg_r  <= 1'b0;
      seen_r <= 1'b0;
    end else if (process) begin
      ph_r   <= ph_nxt;
      rad_r  <= rad_nxt;
      acc_r  <= acc_nxt;
      neg_r  <= neg_nxt;
      seen_r <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= process && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (process && emit) begin
      out_value_r  <= out_value_nxt;
      out_status_r <= out_status_nxt;
      out_term_r   <= out_term_nxt;
      out_end_r    <= out_end_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'd0, out_term_r, out_status_r, out_value_r};
  assign out_tlast  = out_end_r;

endmodule
`default_nettype wire

// File: sv/aip_digit_decode.sv
`default_nettype none
module aip_digit_decode (
  input  wire logic [7:0]     char_code,
  input  aip_pkg::radix_t     radix,
  output aip_pkg::digit_t     digit
);

  always_comb begin
    digit = '{valid: 1'b0, value: 4'd0};
    case (radix)
      aip_pkg::RAD_DEC: begin
        if (char_code >= aip_pkg::CH_0 && char_code <= aip_pkg::CH_9) begin
          digit.valid = 1'b1;
          digit.value = 4'(char_code - aip_pkg::CH_0);
        end
      end
      aip_pkg::RAD_OCT: begin
        if (char_code >= aip_pkg::CH_0 && char_code <= aip_pkg::CH_7) begin
          digit.valid = 1'b1;
          digit.value = 4'(char_code - aip_pkg::CH_0);
        end
      end
      aip_pkg::RAD_BIN: begin
        if (char_code >= aip_pkg::CH_0 && char_code <= aip_pkg::CH_1) begin
          digit.valid = 1'b1;
          digit.value = 4'(char_code - aip_pkg::CH_0);
        end
      end
      aip_pkg::RAD_HEX: begin
        if (char_code >= aip_pkg::CH_0 && char_code <= aip_pkg::CH_9) begin
          digit.valid = 1'b1;
          digit.value = 4'(char_code - aip_pkg::CH_0);
        end else if (char_code >= aip_pkg::CH_LA && char_code <= aip_pkg::CH_LF) begin
          digit.valid = 1'b1;
          digit.value = 4'(char_code - aip_pkg::CH_LA + 8'd10);
        end else if (char_code >= aip_pkg::CH_UA && char_code <= aip_pkg::CH_UF) begin
          digit.valid = 1'b1;
          digit.value = 4'(char_code - aip_pkg::CH_UA + 8'd10);
        end
      end
      default: digit = '{valid: 1'b0, value: 4'd0};
    endcase
  end

endmodule
`default_nettype wire

// File: sv/aip_acc_step.sv
`default_nettype none
module aip_acc_step (
  input  wire logic [63:0]    acc,
  input  aip_pkg::radix_t     radix,
  input  wire logic [3:0]     digit,
  input  wire logic           wide_mode,
  output aip_pkg::acc_step_t  step
);

  logic [68:0] acc_ext;
  logic [68:0] prod;
  logic [68:0] sum;

  assign acc_ext = {5'd0, acc};

  // radix multiply as shift-adds
  always_comb begin
    case (radix)
      aip_pkg::RAD_DEC: prod = (acc_ext << 3) + (acc_ext << 1);
      aip_pkg::RAD_HEX: prod = acc_ext << 4;
      aip_pkg::RAD_OCT: prod = acc_ext << 3;
      aip_pkg::RAD_BIN: prod = acc_ext << 1;
      default:          prod = acc_ext;
    endcase
  end

  assign sum = prod + {65'd0, digit};

  always_comb begin
    step.acc  = sum[63:0];
    step.fits = wide_mode ? (sum[68:64] == 5'd0) : (sum[68:32] == 37'd0);
  end

endmodule
`default_nettype wire
